// ===== src/set_associative_read_cache_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative read cache
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOCIATIVE_READ_CACHE_TOP_MACROS_SVH
`define SET_ASSOCIATIVE_READ_CACHE_TOP_MACROS_SVH

// Same-cycle implication.
`define SARC_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sarc: same-cycle check failed");

// Next-cycle implication.
`define SARC_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sarc: next-cycle check failed");

`endif

// ===== src/sarc_pkg.sv =====
// ----------------------------------------------------------------------------
// sarc_pkg
// Command and status types shared by the cache controller and datapath.
// ----------------------------------------------------------------------------
package sarc_pkg;

  // Result source selected toward the output ports.
  localparam logic [1:0] RESP_NONE  = 2'd0;
  localparam logic [1:0] RESP_WRITE = 2'd1;
  localparam logic [1:0] RESP_HIT   = 2'd2;
  localparam logic [1:0] RESP_MISS  = 2'd3;

  typedef struct packed {
    logic       capture;    // latch request, read tag row of its set
    logic       look;       // compare tags, pick way, start hit read or fill
    logic       fill_step;  // one backing read; from the second step also one line write
    logic       commit;     // write tag and valid for the filled way
    logic       mem_write;  // store one byte into the backing store
    logic [1:0] resp;       // result source, RESP_NONE when idle
  } sarc_cmd_t;

  typedef struct packed {
    logic req_write;  // latched request is a backing store write
    logic req_hit;    // tag compare found the line
    logic fill_last;  // final line byte is written this cycle
  } sarc_status_t;

endpackage

// ===== src/sarc_dp.sv =====
// ----------------------------------------------------------------------------
// sarc_dp
// Cache datapath: backing store, line store, tag rows, valid bits and
// round-robin fill pointers, plus the result mux.
// ----------------------------------------------------------------------------
module sarc_dp #(
  parameter int SETS         = 2,
  parameter int WAYS         = 2,
  parameter int LINE_BYTES   = 8,
  parameter int ADDRESS_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       action,
  input  logic [ADDRESS_BITS-1:0]    address,
  input  logic [7:0]                 write_data,
  input  sarc_pkg::sarc_cmd_t        cmd,
  output sarc_pkg::sarc_status_t     status,
  output logic [7:0]                 read_data,
  output logic                       hit,
  output logic                       way
);
  import sarc_pkg::*;

  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS = $clog2(SETS);
  localparam int WAY_BITS = $clog2(WAYS);
  localparam int OFF_W    = (OFF_BITS > 0) ? OFF_BITS : 1;
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_W    = (WAY_BITS > 0) ? WAY_BITS : 1;
  localparam int TAG_SPAN = ADDRESS_BITS - OFF_BITS - SET_BITS;
  localparam int TAG_W    = (TAG_SPAN > 0) ? TAG_SPAN : 1;
  localparam int ROW_W    = WAYS * TAG_W;
  localparam int CL_DEPTH = SETS * WAYS * LINE_BYTES;
  localparam int CL_BITS  = $clog2(CL_DEPTH);
  localparam int CL_W     = (CL_BITS > 0) ? CL_BITS : 1;
  localparam int MEM_DEPTH = 1 << ADDRESS_BITS;
  localparam int CNT_W    = $clog2(LINE_BYTES + 1);

  // Request registers
  logic                    action_q;
  logic [ADDRESS_BITS-1:0] addr_q;
  logic [7:0]              wdata_q;

  logic [SET_W-1:0]        in_set;
  logic [SET_W-1:0]        set_q;
  logic [TAG_W-1:0]        tag_q;
  logic [OFF_W-1:0]        off_q;
  logic [ADDRESS_BITS-1:0] line_base;
  logic [ADDRESS_BITS-1:0] bk_raddr;

  // Storage
  logic [7:0]       bk_mem   [MEM_DEPTH];
  logic [7:0]       line_mem [CL_DEPTH];
  logic [ROW_W-1:0] tag_mem  [SETS];
  logic [WAYS-1:0]  valid    [SETS];
  logic [WAY_W-1:0] fill_ptr [SETS];

  logic [ROW_W-1:0] tag_row_q;
  logic [ROW_W-1:0] tag_row_next;
  logic [7:0]       bk_rd_q;
  logic [7:0]       line_rd_q;
  logic [7:0]       byte_q;
  logic [WAY_W-1:0] way_q;
  logic [CNT_W-1:0] fill_cnt;

  logic             lookup_hit;
  logic [WAY_W-1:0] lookup_way;
  logic [WAY_W-1:0] victim;
  logic [WAYS-1:0]  valid_row;
  logic [CL_W-1:0]  hit_raddr;
  logic [CL_W-1:0]  fill_waddr;
  logic             fill_wr;

  assign in_set    = SET_W'((address >> OFF_BITS) & ADDRESS_BITS'(SETS - 1));
  assign set_q     = SET_W'((addr_q >> OFF_BITS) & ADDRESS_BITS'(SETS - 1));
  assign tag_q     = TAG_W'(addr_q >> (OFF_BITS + SET_BITS));
  assign off_q     = OFF_W'(addr_q & ADDRESS_BITS'(LINE_BYTES - 1));
  assign line_base = addr_q & ~ADDRESS_BITS'(LINE_BYTES - 1);
  assign bk_raddr  = line_base + ADDRESS_BITS'(fill_cnt);

  assign valid_row = valid[set_q];
  assign victim    = fill_ptr[set_q];

  // Lowest matching way wins.
  always_comb begin
    lookup_hit = 1'b0;
    lookup_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_row[w] && tag_row_q[w*TAG_W +: TAG_W] == tag_q) begin
        lookup_hit = 1'b1;
        lookup_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    tag_row_next = tag_row_q;
    tag_row_next[way_q*TAG_W +: TAG_W] = tag_q;
  end

  assign hit_raddr  = CL_W'((int'(set_q) * WAYS + int'(lookup_way)) * LINE_BYTES
                            + int'(off_q));
  assign fill_waddr = CL_W'((int'(set_q) * WAYS + int'(way_q)) * LINE_BYTES
                            + int'(fill_cnt) - 1);
  // The first fill step only issues a read; writes trail the reads by one.
  assign fill_wr    = cmd.fill_step && (fill_cnt != '0);

  assign status.req_write = action_q;
  assign status.req_hit   = lookup_hit;
  assign status.fill_last = (fill_cnt == CNT_W'(LINE_BYTES));

  // Request capture and tag row storage
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_q  <= action;
      addr_q    <= address;
      wdata_q   <= write_data;
      tag_row_q <= tag_mem[in_set];
    end
    if (cmd.commit) begin
      tag_mem[set_q] <= tag_row_next;
    end
  end

  // Backing store
  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      bk_mem[addr_q] <= wdata_q;
    end
    if (cmd.fill_step) begin
      bk_rd_q <= bk_mem[bk_raddr];
    end
  end

  // Line store
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      line_rd_q <= line_mem[hit_raddr];
    end
    if (fill_wr) begin
      line_mem[fill_waddr] <= bk_rd_q;
    end
  end

  // Keep the requested byte as the fill streams it; latch the chosen way.
  always_ff @(posedge clk) begin
    if (fill_wr && fill_cnt == CNT_W'(off_q) + CNT_W'(1)) begin
      byte_q <= bk_rd_q;
    end
    if (cmd.look) begin
      way_q <= lookup_hit ? lookup_way : victim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
      for (int s = 0; s < SETS; s++) begin
        valid[s]    <= '0;
        fill_ptr[s] <= '0;
      end
    end else begin
      if (cmd.look) begin
        fill_cnt <= '0;
        if (!lookup_hit) begin
          fill_ptr[set_q] <= (victim == WAY_W'(WAYS - 1)) ? '0 : victim + 1'b1;
        end
      end else if (cmd.fill_step) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
      if (cmd.commit) begin
        valid[set_q][way_q] <= 1'b1;
      end
    end
  end

  always_comb begin
    case (cmd.resp)
      RESP_HIT: begin
        read_data = line_rd_q;
        hit       = 1'b1;
        way       = way_q[0];
      end
      RESP_MISS: begin
        read_data = byte_q;
        hit       = 1'b0;
        way       = way_q[0];
      end
      default: begin
        read_data = 8'd0;
        hit       = 1'b0;
        way       = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/sarc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sarc_ctrl
// Cache controller: sequences lookup, store write, line fill, tag commit and response.
// ----------------------------------------------------------------------------
`include "set_associative_read_cache_top_macros.svh"

module sarc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  sarc_pkg::sarc_status_t st,
  output sarc_pkg::sarc_cmd_t    cmd,
  output logic                   busy,
  output logic                   done
);
  import sarc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_HITRD = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_LOOK;
      end
      S_LOOK: begin
        if (st.req_write)    state_next = S_WRITE;
        else if (st.req_hit) state_next = S_HITRD;
        else                 state_next = S_FILL;
      end
      S_FILL: begin
        if (st.fill_last) state_next = S_DONE;
      end
      S_WRITE, S_HITRD, S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.capture   = (state == S_IDLE) && start;
    cmd.look      = (state == S_LOOK) && !st.req_write;
    cmd.fill_step = (state == S_FILL);
    cmd.commit    = (state == S_DONE);
    cmd.mem_write = (state == S_WRITE);
    case (state)
      S_WRITE: cmd.resp = RESP_WRITE;
      S_HITRD: cmd.resp = RESP_HIT;
      S_DONE:  cmd.resp = RESP_MISS;
      default: cmd.resp = RESP_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (cmd.resp != RESP_NONE);

  `SARC_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
  `SARC_ASSERT_NEXT(a_done_frees, done, !done && !busy)
  `SARC_ASSERT_IMP(a_commit_after_fill, cmd.commit, $past(state) == S_FILL)
  `SARC_ASSERT_IMP(a_fill_only_reads, cmd.fill_step, !done && !cmd.look)

endmodule

// ===== src/set_associative_read_cache_top.sv =====
// ----------------------------------------------------------------------------
// set_associative_read_cache_top
// Read-only set-associative byte cache with round-robin fill, in front of
// an on-chip backing store.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive action, address and write_data and raise start;
//   the request is taken at a rising edge with start high and busy low.
//   action 1 stores write_data into the backing store only (cached lines
//   are left as they are); action 0 reads the byte through the cache.
//   Result channel: done is high for exactly one cycle with read_data, hit
//   and way valid in that cycle. There is no backpressure; the receiver
//   must take every result in that cycle.
//   Timing: a write passes the lookup state, which only decodes it, and
//   raises done in the store write state; a read hit does the tag compare
//   and line store read in the lookup state and raises done in the hit
//   read state. A read miss streams one byte per cycle from the single-port
//   backing store into the line, then commits the tag and raises done.
//   busy stays high through done, so one request is in flight at a time.
//   Reset: rst clears valid bits, fill pointers and the controller; no
//   clearing pass runs, so a request may start in the first cycle after.
//   Backing store bytes must be written before a read touches their line.
// ----------------------------------------------------------------------------
module set_associative_read_cache_top #(
  parameter int SETS         = 2,
  parameter int WAYS         = 2,
  parameter int LINE_BYTES   = 8,
  parameter int ADDRESS_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    action,
  input  logic [ADDRESS_BITS-1:0] address,
  input  logic [7:0]              write_data,
  output logic                    done,
  output logic [7:0]              read_data,
  output logic                    hit,
  output logic                    way
);
  import sarc_pkg::*;

  sarc_cmd_t    cmd;
  sarc_status_t status;

  sarc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  sarc_dp #(
    .SETS         (SETS),
    .WAYS         (WAYS),
    .LINE_BYTES   (LINE_BYTES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .action     (action),
    .address    (address),
    .write_data (write_data),
    .cmd        (cmd),
    .status     (status),
    .read_data  (read_data),
    .hit        (hit),
    .way        (way)
  );

endmodule

// ===== bench/tb_set_associative_read_cache_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_associative_read_cache_top
// Drives backing-store writes and cached reads through the command port and
// checks every result against a cycle-free model of the two-way cache.
// ----------------------------------------------------------------------------
module tb_set_associative_read_cache_top;

  localparam bit ACT_READ  = 1'b0;
  localparam bit ACT_WRITE = 1'b1;
  localparam int ITEM_TARGET = 1450;
  localparam int DRAIN_LIMIT = 400;
  localparam int MISS_LATENCY = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       hit;
    logic       way;
  } cache_reply_t;

  class cache_scoreboard;
    logic [7:0]   backing [256];
    logic [7:0]   line_data [4][8];
    logic [3:0]   line_tag [4];
    bit           line_valid [4];
    bit           fill_ptr [2];
    cache_reply_t pending_replies [$];
    int           fail_count;

    function new();
      foreach (line_valid[i]) line_valid[i] = 1'b0;
      foreach (fill_ptr[i]) fill_ptr[i] = 1'b0;
      fail_count = 0;
    endfunction

    function void report(string msg);
      fail_count++;
      $display("ERROR at %0t ns: %s", $time, msg);
    endfunction

    function cache_reply_t predict_access(bit act, logic [7:0] addr, logic [7:0] wdata);
      cache_reply_t r;
      logic [2:0]   off;
      logic         set_sel;
      logic [3:0]   tag;
      logic         w;
      bit           found;
      logic [1:0]   slot;
      off     = addr[2:0];
      set_sel = addr[3];
      tag     = addr[7:4];
      r       = '0;
      if (act == ACT_WRITE) begin
        backing[addr] = wdata;
        return r;
      end
      found = 1'b0;
      w     = 1'b0;
      // lowest matching way wins
      for (int i = 1; i >= 0; i--) begin
        if (line_valid[{set_sel, 1'(i)}] && line_tag[{set_sel, 1'(i)}] == tag) begin
          found = 1'b1;
          w     = 1'(i);
        end
      end
      if (!found) begin
        w                 = fill_ptr[set_sel];
        fill_ptr[set_sel] = ~w;
        slot              = {set_sel, w};
        for (int b = 0; b < 8; b++)
          line_data[slot][3'(b)] = backing[{addr[7:3], 3'(b)}];
        line_tag[slot]   = tag;
        line_valid[slot] = 1'b1;
      end
      r.data = line_data[{set_sel, w}][off];
      r.hit  = found;
      r.way  = w;
      return r;
    endfunction

    function void note_request(bit act, logic [7:0] addr, logic [7:0] wdata);
      pending_replies.push_back(predict_access(act, addr, wdata));
    endfunction

    function void check_reply(logic [7:0] rd, logic h, logic w);
      cache_reply_t e;
      if (pending_replies.size() == 0) begin
        report($sformatf("result with none outstanding: data=%h hit=%b way=%b", rd, h, w));
        return;
      end
      e = pending_replies.pop_front();
      if (rd !== e.data) report($sformatf("read_data %h, want %h", rd, e.data));
      if (h !== e.hit) report($sformatf("hit %b, want %b", h, e.hit));
      if (w !== e.way) report($sformatf("way %b, want %b", w, e.way));
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       start      = 1'b0;
  logic       action     = ACT_READ;
  logic [7:0] address    = 8'h00;
  logic [7:0] write_data = 8'h00;
  logic       busy;
  logic       done;
  logic [7:0] read_data;
  logic       hit;
  logic       way;

  cache_scoreboard sb = new();
  bit              written [256];
  int              item_count = 0;
  int              idle_pct   = 0;
  logic [3:0]      hot_tag [2][3];

  set_associative_read_cache_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .address    (address),
    .write_data (write_data),
    .done       (done),
    .read_data  (read_data),
    .hit        (hit),
    .way        (way)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_reply(read_data, hit, way);
  end

  // Call at a rising edge; returns at the transfer edge or after the idle gap.
  task automatic issue(bit act, logic [7:0] addr, logic [7:0] wdata);
    start      <= 1'b1;
    action     <= act;
    address    <= addr;
    write_data <= wdata;
    do @(posedge clk); while (busy);
    sb.note_request(act, addr, wdata);
    if (act == ACT_WRITE) written[addr] = 1'b1;
    item_count++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // A miss copies the whole line, so load any unwritten byte of it first.
  task automatic read_byte(logic [7:0] addr);
    for (int b = 0; b < 8; b++) begin
      if (!written[{addr[7:3], 3'(b)}]) issue(ACT_WRITE, {addr[7:3], 3'(b)}, 8'($urandom));
    end
    issue(ACT_READ, addr, 8'($urandom));
  endtask

  initial begin
    #2_000_000;
    $display("set_associative_read_cache_top: mismatch");
    $finish;
  end

  initial begin
    int         waited;
    logic [7:0] addr;
    foreach (written[i]) written[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme data, cold miss, hit, stale hit after a store write,
    // first fill of the other set.
    idle_pct = 11;
    for (int i = 0; i < 8; i++)
      issue(ACT_WRITE, 8'(i), (i == 0) ? 8'h00 : (i == 7) ? 8'hFF : 8'($urandom));
    read_byte(8'h00);
    read_byte(8'h07);
    issue(ACT_WRITE, 8'h05, 8'hA5);
    read_byte(8'h05);
    for (int i = 8'hF8; i <= 8'hFF; i++) issue(ACT_WRITE, 8'(i), ~8'(i));
    read_byte(8'hFF);
    read_byte(8'hF8);

    // Random: mostly reads over a small working set per set to force hits and
    // round-robin evictions, with store writes mixed in to make stale lines.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 11 : (phase == 1) ? 53 : 0;
      foreach (hot_tag[s, k]) hot_tag[s][k] = 4'($urandom);
      while (item_count < ITEM_TARGET * (phase + 1) / 3) begin
        if ($urandom_range(0, 99) < 25) begin
          issue(ACT_WRITE, 8'($urandom), 8'($urandom));
        end else begin
          addr = 8'($urandom);
          if ($urandom_range(0, 99) < 70)
            addr[7:4] = hot_tag[addr[3]][2'($urandom_range(0, 2))];
          read_byte(addr);
        end
      end
    end
    start <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (MISS_LATENCY + 4) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    if (sb.fail_count == 0) begin
      $display("set_associative_read_cache_top: match");
    end else begin
      $display("set_associative_read_cache_top: mismatch");
    end
    $finish;
  end

endmodule
